@@ design/mmce_pkg.sv @@
// types, widths and register codes shared by the min/max column envelope design
// no dependencies
package mmce_pkg;

    localparam int TIME_BITS       = 40;
    localparam int SAMPLE_BITS     = 24;
    localparam int PERIOD_BITS     = 16;
    localparam int WIDTH_BITS      = 13;
    localparam int GAP_BITS        = 12;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET      = PERIOD_BITS'(50);
    localparam logic [WIDTH_BITS-1:0]  TRACE_WIDTH_RESET = WIDTH_BITS'(800);
    localparam logic [GAP_BITS-1:0]    GAP_MAX           = {GAP_BITS{1'b1}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_COLUMN_PERIOD = CFG_INDEX_BITS'(0),
        REG_TRACE_WIDTH   = CFG_INDEX_BITS'(1)
    } cfg_reg_t;

    typedef struct packed {
        logic        [TIME_BITS-1:0]   timestamp_ms;
        logic signed [SAMPLE_BITS-1:0] sample;
    } sample_item_t;

    typedef struct packed {
        logic        [TIME_BITS-1:0]   column_index;
        logic signed [SAMPLE_BITS-1:0] column_min;
        logic signed [SAMPLE_BITS-1:0] column_max;
        logic        [GAP_BITS-1:0]    gap_columns;
        logic        [SAMPLE_BITS-1:0] peak_abs;
    } column_result_t;

    typedef struct packed {
        logic        [TIME_BITS-1:0]   column;
        logic signed [SAMPLE_BITS-1:0] sample;
    } column_entry_t;

endpackage

@@ design/mmce_front.sv @@
// front end: takes a sample transaction and finds its column with a bit-serial divider
// depends on mmce_pkg
module mmce_front
    import mmce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sample_item_t           item,
    output logic                   full,
    input  logic [PERIOD_BITS-1:0] period,
    output logic                   q_push,
    output column_entry_t          q_entry,
    input  logic                   q_full
);

    localparam int COUNT_BITS = $clog2(TIME_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    state_t                        state_reg, state_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic [TIME_BITS-1:0]          quo_reg, quo_next;
    logic [PERIOD_BITS-1:0]        rem_reg, rem_next;
    logic [PERIOD_BITS-1:0]        div_reg, div_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;

    logic [PERIOD_BITS:0]          trial;
    logic [PERIOD_BITS:0]          trial_diff;
    logic                          trial_ge;

    assign trial      = {rem_reg, quo_reg[TIME_BITS-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        sample_next = sample_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    state_next  = ST_DIVIDE;
                    count_next  = COUNT_BITS'(TIME_BITS - 1);
                    quo_next    = item.timestamp_ms;
                    rem_next    = '0;
                    div_next    = (period == '0) ? PERIOD_BITS'(1) : period;
                    sample_next = item.sample;
                end
            end
            ST_DIVIDE:
            begin
                // one quotient bit per cycle, restoring
                if (trial_ge)
                begin
                    rem_next = trial_diff[PERIOD_BITS-1:0];
                end
                else
                begin
                    rem_next = trial[PERIOD_BITS-1:0];
                end
                quo_next = {quo_reg[TIME_BITS-2:0], trial_ge};
                if (count_reg == '0)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    count_next = count_reg - COUNT_BITS'(1);
                end
            end
            ST_HOLD:
            begin
                if (!q_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            div_reg    <= '0;
            sample_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            quo_reg    <= quo_next;
            rem_reg    <= rem_next;
            div_reg    <= div_next;
            sample_reg <= sample_next;
        end
    end

    assign full           = (state_reg != ST_IDLE);
    assign q_push         = (state_reg == ST_HOLD) && !q_full;
    assign q_entry.column = quo_reg;
    assign q_entry.sample = sample_reg;

endmodule

@@ design/mmce_queue.sv @@
// short register queue of column entries between front and back
// depends on mmce_pkg
module mmce_queue
    import mmce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  column_entry_t wr_entry,
    output logic          full,
    input  logic          rd,
    output column_entry_t rd_entry,
    output logic          empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    column_entry_t         mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ design/mmce_back.sv @@
// back end: tracks the open column envelope and peak, emits closed columns
// depends on mmce_pkg
module mmce_back
    import mmce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  column_entry_t         q_entry,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [WIDTH_BITS-1:0] trace_width,
    output column_result_t        result,
    output logic                  empty,
    input  logic                  pop
);

    logic                          open_reg, open_next;
    logic [TIME_BITS-1:0]          col_reg, col_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0]        peak_reg, peak_next;
    logic                          res_valid_reg, res_valid_next;
    column_result_t                res_reg, res_next;

    logic [SAMPLE_BITS-1:0]        mag;
    logic [WIDTH_BITS-1:0]         cap;
    logic [GAP_BITS-1:0]           limit;
    logic [TIME_BITS-1:0]          diff;
    logic [GAP_BITS-1:0]           gap;

    assign q_pop = !q_empty && (!res_valid_reg || pop);

    assign mag   = q_entry.sample[SAMPLE_BITS-1] ? (~q_entry.sample + SAMPLE_BITS'(1))
                                                 : q_entry.sample;
    assign cap   = (trace_width == '0) ? '0 : trace_width - WIDTH_BITS'(1);
    assign limit = (cap > WIDTH_BITS'(GAP_MAX)) ? GAP_MAX : cap[GAP_BITS-1:0];
    assign diff  = q_entry.column - col_reg - TIME_BITS'(1);

    always_comb
    begin
        gap = '0;
        if (q_entry.column > col_reg)
        begin
            gap = (diff > TIME_BITS'(limit)) ? limit : diff[GAP_BITS-1:0];
        end
    end

    always_comb
    begin
        open_next      = open_reg;
        col_next       = col_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        peak_next      = peak_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;
        if (q_pop)
        begin
            if (mag > peak_reg)
            begin
                peak_next = mag;
            end
            if (!open_reg)
            begin
                open_next = 1'b1;
                col_next  = q_entry.column;
                min_next  = q_entry.sample;
                max_next  = q_entry.sample;
            end
            else if (q_entry.column == col_reg)
            begin
                if (q_entry.sample < min_reg)
                begin
                    min_next = q_entry.sample;
                end
                if (q_entry.sample > max_reg)
                begin
                    max_next = q_entry.sample;
                end
            end
            else
            begin
                res_valid_next        = 1'b1;
                res_next.column_index = col_reg;
                res_next.column_min   = min_reg;
                res_next.column_max   = max_reg;
                res_next.gap_columns  = gap;
                res_next.peak_abs     = (mag > peak_reg) ? mag : peak_reg;
                col_next              = q_entry.column;
                min_next              = q_entry.sample;
                max_next              = q_entry.sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            col_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            peak_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            open_reg      <= open_next;
            col_reg       <= col_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            peak_reg      <= peak_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign result = res_reg;
    assign empty  = !res_valid_reg;

endmodule

@@ design/min_max_column_envelope.sv @@
// top level of the min/max column envelope decimator
// depends on mmce_pkg, mmce_front, mmce_queue, mmce_back
//
// Takes timestamped signed samples and reduces them to display columns of
// column_period_ms milliseconds each. A sample in a new column closes the open
// one and yields one result transaction: the closed column's index, its minimum
// and maximum, the number of empty columns skipped before the new one (capped at
// trace_width - 1 and at 4095) and the peak magnitude seen since reset. The first
// sample after reset only opens a column. The column number of each input
// transaction comes from a bit-serial divider that produces one quotient bit
// per cycle, and the front end takes no new sample until its entry is queued.
// A short queue and a result register let input and output stall independently.
// Configuration must be written only while the block is idle; the block does not enforce it.
module min_max_column_envelope
    import mmce_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  sample_item_t              item,
    output logic                      full,
    output logic                      empty,
    input  logic                      pop,
    output column_result_t            result,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [PERIOD_BITS-1:0] period_reg;
    logic [WIDTH_BITS-1:0]  width_reg;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    column_entry_t          q_wr_entry;
    column_entry_t          q_rd_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            width_reg  <= TRACE_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLUMN_PERIOD: period_reg <= cfg_data[PERIOD_BITS-1:0];
                REG_TRACE_WIDTH:   width_reg  <= cfg_data[WIDTH_BITS-1:0];
                default:           ;
            endcase
        end
    end

    mmce_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .period  (period_reg),
        .q_push  (q_push),
        .q_entry (q_wr_entry),
        .q_full  (q_full)
    );

    mmce_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .rd       (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    mmce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_entry     (q_rd_entry),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .trace_width (width_reg),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("front end not busy after accepting a transaction");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("front end pushed into a full queue");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.column_min <= result.column_max)
        else $error("closed column minimum above its maximum");

    a_peak_covers_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.column_max[SAMPLE_BITS-1] |->
            result.peak_abs >= result.column_max)
        else $error("peak magnitude below closed column maximum");
`endif

endmodule
